@@ hdl/kld_pkg.sv @@
`default_nettype none

package kld_pkg;

   // Field widths
   localparam int CODE_W     = 8;
   localparam int CHAR_W     = 8;
   localparam int MOD_W      = 6;
   localparam int IDX_W      = 8;
   localparam int SCREEN_W   = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int KEYMAP_AW  = 9;
   localparam int LINE_MAX_DEFAULT = 256;

   // Scancode and character constants
   localparam logic [CODE_W-1:0] RELEASE_BASE = 8'h80;
   localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BS   = 8'h08;
   localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CH_SIX  = 8'h36;

   // Modifier bit positions
   localparam int MOD_SHIFT = 0;
   localparam int MOD_ALT   = 2;
   localparam int MOD_CAPS  = 3;
   localparam int MOD_LOCK0 = 3;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_SHIFT  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_CTRL   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ALT    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_CAPS   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_NUM    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SCROLL = 3'd5;

   // Configuration reset values
   localparam logic [CODE_W-1:0] SHIFT_RST  = 8'd42;
   localparam logic [CODE_W-1:0] CTRL_RST   = 8'd29;
   localparam logic [CODE_W-1:0] ALT_RST    = 8'd56;
   localparam logic [CODE_W-1:0] CAPS_RST   = 8'd58;
   localparam logic [CODE_W-1:0] NUM_RST    = 8'd69;
   localparam logic [CODE_W-1:0] SCROLL_RST = 8'd70;

   typedef enum logic [1:0] {
      FUNC_EVENT = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_START = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // Keymap write request
   typedef struct packed {
      logic                 en;
      logic [KEYMAP_AW-1:0] addr;
      logic [CHAR_W-1:0]    data;
   } kld_wr_type;

   // Item handed from the decode stage to the line stage
   typedef struct packed {
      func_type         func;
      logic             lookup;
      logic [MOD_W-1:0] mods;
   } kld_s1_type;

   // Result item
   typedef struct packed {
      logic                dropped;
      logic [MOD_W-1:0]    modifier_bits;
      logic [SCREEN_W-1:0] screen_number;
      logic                switch_screen;
      logic                line_done;
      logic [CHAR_W-1:0]   buf_data;
      logic [IDX_W-1:0]    buf_index;
      logic                buf_write;
      logic                echo;
      logic [CHAR_W-1:0]   key_char;
   } kld_rsp_type;

endpackage

`default_nettype wire

@@ hdl/scancode_keyboard_line_decoder.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tuser: func; tdata: scancode, table_index,
//                                             table_shifted, table_char
// rsp_      out        rsp_tvalid/rsp_tready  tdata: result fields, key_char lowest
// csr_      in         csr_we                 csr_addr register index, csr_wdata value
//
// One item per cycle unless the keymap is being cleared or rsp_ stalls; stage one and the
// keymap read register on acceptance, then line editing fills the output register.
// After reset the keymap is swept to zero, one entry a cycle, and req_tready stays low;
// configuration writes are taken throughout.
// A stalled rsp_ side holds the result and stops the pipe; one more item fills stage one,
// then req_tready stays low.

module scancode_keyboard_line_decoder
   import kld_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CODE_W-1:0]     csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [1:0] func
   input  wire logic [1:0]            req_tuser,
   // [7:0] scancode, [15:8] table_index, [16] table_shifted, [24:17] table_char
   input  wire logic [31:0]           req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] key_char, [8] echo, [9] buf_write, [17:10] buf_index, [25:18] buf_data,
   // [26] line_done, [27] switch_screen, [30:28] screen_number,
   // [36:31] modifier_bits, [37] dropped
   output logic [39:0]                rsp_tdata
);

   kld_wr_type           map_wr;
   logic                 map_rd_en;
   logic [KEYMAP_AW-1:0] map_rd_addr;
   logic [CHAR_W-1:0]    map_rd_data;
   logic                 map_busy;
   logic                 s1_valid;
   kld_s1_type           s1_item;
   logic                 s1_take;
   kld_rsp_type          rsp_item;

   kld_keymap u_keymap (
      .clock   (clock),
      .reset   (reset),
      .wr      (map_wr),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data),
      .busy    (map_busy)
   );

   kld_decode u_decode (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_func          (func_type'(req_tuser)),
      .req_scancode      (req_tdata[7:0]),
      .req_table_index   (req_tdata[15:8]),
      .req_table_shifted (req_tdata[16]),
      .req_table_char    (req_tdata[24:17]),
      .map_busy          (map_busy),
      .map_wr            (map_wr),
      .map_rd_en         (map_rd_en),
      .map_rd_addr       (map_rd_addr),
      .s1_valid          (s1_valid),
      .s1_item           (s1_item),
      .s1_take           (s1_take)
   );

   kld_line #(
      .LINE_MAX (LINE_MAX)
   ) u_line (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .map_data  (map_rd_data),
      .s1_take   (s1_take),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   // Pack the result fields
   assign rsp_tdata = {2'b00, rsp_item};

   // No item is taken while the keymap is being cleared
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      map_busy |-> !req_tready)
      else $error("item accepted during keymap clear");

   // Screen switch never writes the line buffer
   a_switch_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_item.switch_screen && rsp_item.buf_write))
      else $error("screen switch with buffer write");

   // A dropped character is neither echoed nor written
   a_drop_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_item.dropped) |-> (!rsp_item.buf_write && !rsp_item.echo))
      else $error("dropped character written");

   // Newline writes the terminator
   a_done_term: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_item.line_done) |-> (rsp_item.buf_write && rsp_item.buf_data == '0))
      else $error("line end without terminator");

   // Keymap read and load never come from the same cycle
   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      !(map_rd_en && map_wr.en))
      else $error("keymap read and write in one cycle");

endmodule

`default_nettype wire

@@ hdl/kld_keymap.sv @@
`default_nettype none

module kld_keymap
   import kld_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire kld_wr_type           wr,
   input  wire logic                 rd_en,
   input  wire logic [KEYMAP_AW-1:0] rd_addr,
   output logic [CHAR_W-1:0]         rd_data,
   output logic                      busy
);

   localparam int DEPTH = 2 ** KEYMAP_AW;

   logic [CHAR_W-1:0]    mem [DEPTH];
   logic                 clr_busy_ff, clr_busy_in;
   logic [KEYMAP_AW-1:0] clr_addr_ff, clr_addr_in;
   logic                 mem_we;
   logic [KEYMAP_AW-1:0] mem_waddr;
   logic [CHAR_W-1:0]    mem_wdata;
   logic [CHAR_W-1:0]    rd_data_ff;

   // Sweep every entry to zero after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == KEYMAP_AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Select the clearing sweep or a load
   always_comb begin
      mem_we    = clr_busy_ff | wr.en;
      mem_waddr = clr_busy_ff ? clr_addr_ff : wr.addr;
      mem_wdata = clr_busy_ff ? '0 : wr.data;
   end

   // Single write port, registered read; read and write come from different items
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

`default_nettype wire

@@ hdl/kld_decode.sv @@
`default_nettype none

module kld_decode
   import kld_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CODE_W-1:0]     csr_wdata,
   // input item
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire func_type              req_func,
   input  wire logic [CODE_W-1:0]     req_scancode,
   input  wire logic [IDX_W-1:0]      req_table_index,
   input  wire logic                  req_table_shifted,
   input  wire logic [CHAR_W-1:0]     req_table_char,
   input  wire logic                  map_busy,
   // keymap access
   output kld_wr_type                 map_wr,
   output logic                       map_rd_en,
   output logic [KEYMAP_AW-1:0]       map_rd_addr,
   // to line stage
   output logic                       s1_valid,
   output kld_s1_type                 s1_item,
   input  wire logic                  s1_take
);

   logic [CODE_W-1:0] shift_ff, ctrl_ff, alt_ff, caps_ff, num_ff, scroll_ff;
   logic [MOD_W-1:0]  mod_ff, mod_in;
   logic              s1_valid_ff, s1_valid_in;
   kld_s1_type        s1_item_ff, s1_item_in;
   logic              accept;
   logic              is_rel;
   logic [CODE_W-1:0] base;
   logic [2:0]        hold_hit, lock_hit;
   logic [2:0]        hold_sel, lock_sel;
   logic              lookup;

   // Configuration writes; indexes beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= SHIFT_RST;
         ctrl_ff   <= CTRL_RST;
         alt_ff    <= ALT_RST;
         caps_ff   <= CAPS_RST;
         num_ff    <= NUM_RST;
         scroll_ff <= SCROLL_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_SHIFT:  shift_ff  <= csr_wdata;
            REG_CTRL:   ctrl_ff   <= csr_wdata;
            REG_ALT:    alt_ff    <= csr_wdata;
            REG_CAPS:   caps_ff   <= csr_wdata;
            REG_NUM:    num_ff    <= csr_wdata;
            REG_SCROLL: scroll_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Take a new item when the keymap is not being cleared and stage one is empty or moving on
   assign req_ready = !map_busy && (!s1_valid_ff || s1_take);
   assign accept    = req_valid && req_ready;

   // Match held and lock keys, first match wins
   always_comb begin
      is_rel   = req_scancode > RELEASE_BASE;
      base     = is_rel ? (req_scancode - RELEASE_BASE) : req_scancode;
      hold_hit = {base == alt_ff, base == ctrl_ff, base == shift_ff};
      lock_hit = {req_scancode == scroll_ff, req_scancode == num_ff,
                  req_scancode == caps_ff};
      hold_sel = hold_hit & ~{hold_hit[1] | hold_hit[0], hold_hit[0], 1'b0};
      lock_sel = lock_hit & ~{lock_hit[1] | lock_hit[0], lock_hit[0], 1'b0};
   end

   // Update modifiers and decide on a keymap lookup
   always_comb begin
      mod_in = mod_ff;
      lookup = 1'b0;
      if (is_rel) begin
         mod_in = mod_ff & ~{3'b000, hold_sel};
      end else if (hold_hit != '0) begin
         mod_in = mod_ff | {3'b000, hold_sel};
      end else if (lock_hit != '0) begin
         mod_in = mod_ff ^ {lock_sel, 3'b000};
      end else begin
         lookup = 1'b1;
      end
   end

   // Drive keymap ports
   always_comb begin
      map_wr.en   = accept && (req_func == FUNC_LOAD);
      map_wr.addr = {req_table_shifted, req_table_index};
      map_wr.data = req_table_char;
      map_rd_en   = accept && (req_func == FUNC_EVENT) && lookup;
      map_rd_addr = {mod_ff[MOD_SHIFT] | mod_ff[MOD_CAPS], req_scancode};
   end

   // Load stage one
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (accept) begin
         s1_valid_in       = 1'b1;
         s1_item_in.func   = req_func;
         s1_item_in.lookup = 1'b0;
         s1_item_in.mods   = mod_ff;
         unique case (req_func)
            FUNC_EVENT: begin
               s1_item_in.lookup = lookup;
               s1_item_in.mods   = mod_in;
            end
            FUNC_LOAD, FUNC_START, FUNC_NONE: ;
            default: ;
         endcase
      end else if (s1_take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept && (req_func == FUNC_EVENT)) begin
            mod_ff <= mod_in;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;

endmodule

`default_nettype wire

@@ hdl/kld_line.sv @@
`default_nettype none

module kld_line
   import kld_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              s1_valid,
   input  wire kld_s1_type        s1_item,
   input  wire logic [CHAR_W-1:0] map_data,
   output logic                   s1_take,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output kld_rsp_type            rsp_item
);

   localparam int LP_W = $clog2(LINE_MAX + 1);

   logic [LP_W-1:0] pos_ff, pos_in;
   logic [LP_W-1:0] pos_m1, pos_m2;
   logic            rsp_valid_ff;
   kld_rsp_type     rsp_ff, res;
   logic [CHAR_W-1:0] ch;

   // Advance when the output register is free or being emptied
   assign s1_take = s1_valid && (!rsp_valid_ff || rsp_ready);

   // Line editing
   always_comb begin
      ch     = s1_item.lookup ? map_data : '0;
      pos_m1 = pos_ff - 1'b1;
      pos_m2 = pos_ff - 2'd2;
      pos_in = pos_ff;
      res    = '0;
      res.key_char      = ch;
      res.modifier_bits = s1_item.mods;
      if (s1_item.func == FUNC_START) begin
         if (pos_ff == '0) begin
            pos_in = LP_W'(1);
         end
      end else if (s1_item.mods[MOD_ALT] && ch >= CH_ZERO && ch <= CH_SIX) begin
         res.switch_screen = 1'b1;
         res.screen_number = SCREEN_W'(ch - CH_ZERO);
      end else if (pos_ff != '0) begin
         if (ch == CH_NL) begin
            res.echo      = 1'b1;
            res.buf_write = 1'b1;
            res.buf_index = IDX_W'(pos_m1);
            res.line_done = 1'b1;
            pos_in        = '0;
         end else if (ch == CH_BS) begin
            if (pos_ff > LP_W'(1)) begin
               res.echo      = 1'b1;
               res.buf_write = 1'b1;
               res.buf_index = IDX_W'(pos_m2);
               pos_in        = pos_m1;
            end
         end else if (ch != '0) begin
            if (pos_ff >= LP_W'(LINE_MAX)) begin
               res.dropped = 1'b1;
            end else begin
               res.echo      = 1'b1;
               res.buf_write = 1'b1;
               res.buf_index = IDX_W'(pos_m1);
               res.buf_data  = ch;
               pos_in        = pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_take) begin
            pos_ff       <= pos_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (s1_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

@@ tb/kld_decode_checker.sv @@
`default_nettype none

module kld_decode_checker
   import kld_pkg::*;
#(
   parameter int LINE_MAX = LINE_MAX_DEFAULT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CODE_W-1:0]     csr_wdata,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // [1:0] func
   input  wire logic [1:0]            req_tuser,
   // [7:0] scancode, [15:8] table_index, [16] table_shifted, [24:17] table_char
   input  wire logic [31:0]           req_tdata,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] key_char, [8] echo, [9] buf_write, [17:10] buf_index, [25:18] buf_data,
   // [26] line_done, [27] switch_screen, [30:28] screen_number,
   // [36:31] modifier_bits, [37] dropped
   input  wire logic [39:0]           rsp_tdata,
   output int                         errors,
   output int                         pending
);

   localparam int RSP_W = $bits(kld_rsp_type);

   // Shadow of the decoder: key registers, modifiers, line position, keymap
   logic [CODE_W-1:0] key_codes [0:5];
   logic [MOD_W-1:0]  mod_state;
   logic [8:0]        line_pos;
   logic [CHAR_W-1:0] keymap [0:(1 << KEYMAP_AW)-1];
   kld_rsp_type       awaited_decodes [$];
   int                results_seen;

   task automatic report_mismatch(input string what);
      errors++;
      $display("mismatch on result %0d: %s", results_seen, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
   endtask

   // Index of the first key register in a group of three matching the code, or -1
   function automatic int match_key(input logic [CODE_W-1:0] code, input int first);
      for (int i = 0; i < 3; i++)
         if (key_codes[first + i] == code) return i;
      return -1;
   endfunction

   // Apply one item to the shadow state and return the result it produces
   function automatic kld_rsp_type decode_key_item(input func_type func, input logic [31:0] data);
      kld_rsp_type       r;
      logic [CODE_W-1:0] code;
      logic [CHAR_W-1:0] ch;
      logic [CHAR_W-1:0] offset;
      logic [8:0]        slot;
      int                held;
      int                lock;
      r = '0;
      code = data[7:0];
      ch = '0;
      case (func)
         FUNC_LOAD: keymap[{data[16], data[15:8]}] = data[24:17];
         FUNC_START: if (line_pos == 0) line_pos = 9'd1;
         FUNC_EVENT: begin
            held = match_key(code, 0);
            lock = match_key(code, MOD_LOCK0);
            // Release clears a held key only; lock releases fall through silently
            if (code > RELEASE_BASE) begin
               held = match_key(code - RELEASE_BASE, 0);
               if (held >= 0) mod_state[held] = 1'b0;
            end else if (held >= 0) begin
               mod_state[held] = 1'b1;
            end else if (lock >= 0) begin
               mod_state[MOD_LOCK0 + lock] = ~mod_state[MOD_LOCK0 + lock];
            end else begin
               ch = keymap[{mod_state[MOD_SHIFT] | mod_state[MOD_CAPS], code}];
            end
            r.key_char = ch;

            // Screen switch wins over line editing
            if (mod_state[MOD_ALT] && ch >= CH_ZERO && ch <= CH_SIX) begin
               offset = ch - CH_ZERO;
               r.switch_screen = 1'b1;
               r.screen_number = offset[SCREEN_W-1:0];
            end else if (line_pos != 0) begin
               if (ch == CH_NL) begin
                  slot = line_pos - 9'd1;
                  r.echo = 1'b1;
                  r.buf_write = 1'b1;
                  r.buf_index = slot[7:0];
                  r.line_done = 1'b1;
                  line_pos = '0;
               end else if (ch == CH_BS) begin
                  if (line_pos > 1) begin
                     line_pos = line_pos - 9'd1;
                     slot = line_pos - 9'd1;
                     r.echo = 1'b1;
                     r.buf_write = 1'b1;
                     r.buf_index = slot[7:0];
                  end
               end else if (ch != 0) begin
                  if (line_pos >= LINE_MAX) begin
                     r.dropped = 1'b1;
                  end else begin
                     slot = line_pos - 9'd1;
                     r.echo = 1'b1;
                     r.buf_write = 1'b1;
                     r.buf_index = slot[7:0];
                     r.buf_data = ch;
                     line_pos = line_pos + 9'd1;
                  end
               end
            end
         end
         default: ;
      endcase
      r.modifier_bits = mod_state;
      return r;
   endfunction

   // Track register writes, compare results, queue predictions
   always @(posedge clock) begin
      kld_rsp_type got;
      kld_rsp_type want;
      if (reset) begin
         key_codes[REG_SHIFT]  = SHIFT_RST;
         key_codes[REG_CTRL]   = CTRL_RST;
         key_codes[REG_ALT]    = ALT_RST;
         key_codes[REG_CAPS]   = CAPS_RST;
         key_codes[REG_NUM]    = NUM_RST;
         key_codes[REG_SCROLL] = SCROLL_RST;
         mod_state = '0;
         line_pos = '0;
         for (int i = 0; i < (1 << KEYMAP_AW); i++) keymap[i] = '0;
         awaited_decodes.delete();
         results_seen = 0;
         pending = 0;
         errors = 0;
      end else begin
         if (csr_we && csr_addr <= REG_SCROLL) key_codes[csr_addr] = csr_wdata;

         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (awaited_decodes.size() == 0) begin
               report_mismatch("result with no item waiting");
            end else begin
               want = awaited_decodes.pop_front();
               got = kld_rsp_type'(rsp_tdata[RSP_W-1:0]);
               check_field("key_char", got.key_char, want.key_char);
               check_field("echo", got.echo, want.echo);
               check_field("buf_write", got.buf_write, want.buf_write);
               check_field("buf_index", got.buf_index, want.buf_index);
               check_field("buf_data", got.buf_data, want.buf_data);
               check_field("line_done", got.line_done, want.line_done);
               check_field("switch_screen", got.switch_screen, want.switch_screen);
               check_field("screen_number", got.screen_number, want.screen_number);
               check_field("modifier_bits", got.modifier_bits, want.modifier_bits);
               check_field("dropped", got.dropped, want.dropped);
               check_field("padding", rsp_tdata[39:RSP_W], '0);
            end
         end

         if (req_tvalid && req_tready)
            awaited_decodes.push_back(decode_key_item(func_type'(req_tuser), req_tdata));
         pending = awaited_decodes.size();
      end
   end

endmodule

`default_nettype wire

@@ tb/scancode_keyboard_line_decoder_tb.sv @@
`default_nettype none

module scancode_keyboard_line_decoder_tb;
   import kld_pkg::*;

   localparam int LINE_MAX    = LINE_MAX_DEFAULT;
   localparam int CYCLE_LIMIT = 300000;

   // Keymap layout used by the typing stimulus
   localparam logic [CODE_W-1:0] KEY_DIGIT0 = 8'h02;
   localparam logic [CODE_W-1:0] KEY_BS     = 8'h0E;
   localparam logic [CODE_W-1:0] KEY_NL     = 8'h1C;
   localparam logic [CODE_W-1:0] KEY_LAST   = 8'h1F;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CODE_W-1:0]     csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [1:0]            req_tuser;   // [1:0] func
   // [7:0] scancode, [15:8] table_index, [16] table_shifted, [24:17] table_char
   logic [31:0]           req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [7:0] key_char, [8] echo, [9] buf_write, [17:10] buf_index, [25:18] buf_data,
   // [26] line_done, [27] switch_screen, [30:28] screen_number,
   // [36:31] modifier_bits, [37] dropped
   logic [39:0]           rsp_tdata;

   int                    errors;
   int                    pending;
   int                    cycles = 0;
   logic [CODE_W-1:0]     key_cfg [0:5];
   bit                    send_burst;
   bit                    take_burst;

   scancode_keyboard_line_decoder #(.LINE_MAX(LINE_MAX)) dut (.*);

   kld_decode_checker #(.LINE_MAX(LINE_MAX)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Present one item after a random gap and hold it until taken
   task automatic send_item(input func_type func, input logic [7:0] code, input logic [7:0] idx,
                            input logic shifted, input logic [7:0] ch);
      int gap;
      if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {7'b0, ch, shifted, idx, code};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic key_event(input logic [7:0] code);
      send_item(FUNC_EVENT, code, 8'($urandom), 1'($urandom), 8'($urandom));
   endtask

   task automatic load_key(input logic [7:0] idx, input logic shifted, input logic [7:0] ch);
      send_item(FUNC_LOAD, 8'($urandom), idx, shifted, ch);
   endtask

   task automatic start_line;
      send_item(FUNC_START, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
   endtask

   // Hold off until every outstanding item has its result
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write all six key registers back to back; call only when idle
   task automatic set_keys(input logic [7:0] s, input logic [7:0] c, input logic [7:0] a,
                           input logic [7:0] cp, input logic [7:0] n, input logic [7:0] sc);
      logic [7:0] vals [0:5];
      vals = '{s, c, a, cp, n, sc};
      for (int i = REG_SHIFT; i <= REG_SCROLL; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= CSR_ADDR_W'(i);
         csr_wdata <= vals[i];
         key_cfg[i] = vals[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] layout_char(input logic [7:0] code);
      if (code >= KEY_DIGIT0 && code <= KEY_DIGIT0 + 8'd7) return CH_ZERO + (code - KEY_DIGIT0);
      if (code == KEY_NL) return CH_NL;
      if (code == KEY_BS) return CH_BS;
      return 8'($urandom_range(8'h21, 8'h7E));
   endfunction

   // One item of a typing session: mostly keys, some modifiers, some noise
   task automatic session_item;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)      key_event(8'($urandom_range(KEY_DIGIT0, KEY_LAST)));
      else if (pick < 58) key_event(KEY_BS);
      else if (pick < 64) key_event(KEY_NL);
      else if (pick < 76) key_event(key_cfg[$urandom_range(0, 5)]);
      else if (pick < 88) key_event(key_cfg[$urandom_range(0, 5)] + RELEASE_BASE);
      else if (pick < 93) key_event(8'($urandom));
      else if (pick < 96) load_key(8'($urandom_range(8'h20, 8'hFF)), 1'($urandom), 8'($urandom));
      else if (pick < 98) start_line;
      else send_item(FUNC_NONE, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
   endtask

   task automatic run_sessions(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) != 0) begin
            start_line;
            sent++;
         end
         len = $urandom_range(1, 24);
         repeat (len) session_item;
         sent += len;
         if ($urandom_range(0, 4) != 0) begin
            key_event(KEY_NL);
            sent++;
         end
      end
   endtask

   // Result side: random stalls with stretches of none
   initial begin
      int stall;
      rsp_tready = 1'b0;
      take_burst = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) take_burst = ~take_burst;
         stall = take_burst ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      send_burst = 1'b0;
      key_cfg    = '{SHIFT_RST, CTRL_RST, ALT_RST, CAPS_RST, NUM_RST, SCROLL_RST};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: unknown function, extremes, empty keymap, line editing corners
      send_item(FUNC_NONE, 8'hFF, 8'hFF, 1'b1, 8'hFF);
      key_event(8'h00);
      key_event(8'hFF);
      key_event(RELEASE_BASE);
      load_key(8'h00, 1'b0, 8'hFF);
      load_key(8'hFF, 1'b1, 8'h00);
      key_event(8'h00);
      load_key(KEY_NL, 1'b0, CH_NL);
      load_key(KEY_BS, 1'b0, CH_BS);
      load_key(KEY_DIGIT0, 1'b0, CH_ZERO);
      load_key(KEY_DIGIT0 + 8'd6, 1'b0, CH_SIX);
      load_key(KEY_DIGIT0 + 8'd7, 1'b0, CH_SIX + 8'd1);
      key_event(KEY_BS);
      start_line;
      key_event(KEY_BS);
      key_event(8'h00);
      start_line;
      key_event(KEY_BS);
      key_event(key_cfg[REG_ALT]);
      key_event(KEY_DIGIT0);
      key_event(KEY_DIGIT0 + 8'd6);
      key_event(KEY_DIGIT0 + 8'd7);
      key_event(key_cfg[REG_ALT] + RELEASE_BASE);
      key_event(key_cfg[REG_CAPS]);
      key_event(key_cfg[REG_CAPS] + RELEASE_BASE);
      key_event(key_cfg[REG_CAPS]);
      key_event(KEY_NL);

      // Fill both keymap halves for the typing range
      for (int code = KEY_DIGIT0; code <= KEY_LAST; code++) begin
         load_key(8'(code), 1'b0, layout_char(8'(code)));
         load_key(8'(code), 1'b1, layout_char(8'(code)));
      end

      // Run one line past full, back up, then end it
      start_line;
      repeat (258) key_event(8'($urandom_range(8'h10, 8'h1B)));
      key_event(KEY_BS);
      key_event(8'h10);
      key_event(8'h11);
      key_event(KEY_NL);

      run_sessions(80);

      // Extreme register values
      drain;
      set_keys(8'h00, 8'hFF, RELEASE_BASE, 8'h01, 8'h7F, 8'hFE);
      run_sessions(80);

      // Equal registers: held keys take priority, first match wins
      drain;
      set_keys(8'h2A, 8'h2A, 8'h38, 8'h2A, 8'h11, 8'h11);
      run_sessions(80);

      drain;
      set_keys(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom));
      run_sessions(80);

      drain;
      set_keys(SHIFT_RST, CTRL_RST, ALT_RST, CAPS_RST, NUM_RST, SCROLL_RST);
      run_sessions(80);

      drain;
      repeat (10) @(negedge clock);
      if (errors == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
